// ===== rtl/core/four_way_cuckoo_hash_table_top_defines.svh =====
// Assertion macros for the cuckoo hash table checker
`ifndef FOUR_WAY_CUCKOO_HASH_TABLE_TOP_DEFINES_SVH
`define FOUR_WAY_CUCKOO_HASH_TABLE_TOP_DEFINES_SVH

`define CHT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cuckoo table check failed");

`define CHT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cuckoo table check failed");

`endif

// ===== rtl/core/cht_pkg.sv =====
package cht_pkg;

   localparam int SubDepth    = 256;
   localparam int Ways        = 4;
   localparam int SlotCount   = Ways * SubDepth;
   localparam int IdxW        = $clog2(SubDepth);
   localparam int SlotW       = $clog2(SlotCount);
   localparam int KeyMaxBytes = 8;
   localparam int KeyW        = 8 * KeyMaxBytes;
   localparam int ValueWidth  = 32;
   localparam int WordW       = 1 + KeyW + 4 + ValueWidth;  // valid, key, length, value
   localparam int MaxKicks    = 32;
   localparam int KickW       = $clog2(MaxKicks + 2);
   localparam int LogW        = $clog2(MaxKicks + 1);
   localparam int CountW      = 11;
   localparam int SizeW       = 9;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_REPLACED = 2'd1;
   localparam logic [1:0] ST_ABSENT   = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]                  kind;
      logic [8*KeyMaxBytes-1:0]    key_bytes;
      logic [3:0]                  key_length;
      logic [ValueWidth-1:0]       value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [ValueWidth-1:0] value_out;
      logic [CountW-1:0]     occupancy;
   } rsp_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE    = 4'd0,
      OP_LOAD    = 4'd1,  // capture request into the hand
      OP_HASH    = 4'd2,  // start hashing the hand for way_sel
      OP_READ    = 4'd3,  // issue memory read at hashed slot
      OP_SETVAL  = 4'd4,  // overwrite value at matched slot
      OP_CLRVAL  = 4'd5,  // clear valid at matched slot
      OP_SWAP    = 4'd6,  // write hand into slot, read data becomes hand
      OP_UNDO    = 4'd7,  // read the newest logged slot for undo
      OP_USWAP   = 4'd8,  // swap at undo slot
      OP_LOOKVAL = 4'd9,  // latch value of match
      OP_INIT    = 4'd10  // clear one slot of the clearing pass
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] way_sel;
      logic       cnt_inc;
      logic       cnt_dec;
   } cmd_type;

   typedef struct packed {
      logic hash_done;
      logic match;     // read slot valid and key equal to request
      logic hand_free; // hand holds an empty cell
      logic hand_own;  // hand holds the request key
      logic kick_max;
      logic log_empty;
      logic init_last; // clearing pass at its last slot
   } sts_type;

endpackage

// ===== rtl/core/cht_hash.sv =====
// Byte-serial hash of one key for one way, one byte per cycle, then reduction
module cht_hash (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [1:0]                                way,
   input  logic [8*cht_pkg::KeyMaxBytes-1:0]         key,
   input  logic [3:0]                                len,
   input  logic [cht_pkg::SizeW-1:0]                 modulus,
   output logic                                      done,
   output logic [cht_pkg::IdxW-1:0]                  index
);
   typedef enum logic [2:0] {
      H_IDLE = 3'b001,
      H_BYTE = 3'b010,
      H_MOD  = 3'b100
   } hstate_type;

   hstate_type hs_ff, hs_in;
   logic [63:0] h_ff, h_in;
   logic [3:0]  i_ff, i_in;
   logic [6:0]  m_ff, m_in;        // remainder bit position
   logic [cht_pkg::SizeW:0] r_ff, r_in;
   logic [63:0] b;
   logic [63:0] step;
   logic [cht_pkg::SizeW+1:0] trial;

   always_comb begin
      b = {56'd0, key[8*i_ff[2:0] +: 8]};
      case (way)
         2'd0: step = b + (h_ff << 6) + (h_ff << 16) - h_ff;
         2'd1: step = (h_ff << 5) + h_ff + b;
         2'd2: step = (h_ff << 7) ^ (h_ff - b);
         default: step = ((h_ff << 10) ^ (h_ff >> 6)) + b;
      endcase
      trial = {r_ff, h_ff[m_ff[5:0]]} - {2'd0, modulus};
   end

   always_comb begin
      hs_in = hs_ff;
      h_in  = h_ff;
      i_in  = i_ff;
      m_in  = m_ff;
      r_in  = r_ff;
      case (hs_ff)
         H_IDLE: begin
            if (start) begin
               case (way)
                  2'd0: h_in = 64'd0;
                  2'd1: h_in = 64'd5381;
                  2'd2: h_in = 64'd56923;
                  default: h_in = 64'd77317;
               endcase
               i_in  = 4'd0;
               hs_in = H_BYTE;
            end
         end
         H_BYTE: begin
            if (i_ff == len) begin
               hs_in = H_MOD;
               m_in  = 7'd63;
               r_in  = '0;
            end else begin
               h_in = step;
               i_in = i_ff + 4'd1;
            end
         end
         H_MOD: begin
            // restoring remainder, one bit a cycle
            if (trial[cht_pkg::SizeW+1]) r_in = {r_ff[cht_pkg::SizeW-1:0], h_ff[m_ff[5:0]]};
            else r_in = trial[cht_pkg::SizeW:0];
            m_in = m_ff - 7'd1;
            if (m_ff == 7'd0) hs_in = H_IDLE;
         end
         default: hs_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) hs_ff <= H_IDLE;
      else hs_ff <= hs_in;
      h_ff <= h_in;
      i_ff <= i_in;
      m_ff <= m_in;
      r_ff <= r_in;
   end

   assign done  = (hs_ff == H_IDLE);
   assign index = r_ff[cht_pkg::IdxW-1:0];
endmodule

// ===== rtl/core/cht_datapath.sv =====
module cht_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cht_pkg::req_type              req,
   input  logic [cht_pkg::SizeW-1:0]     size,
   input  cht_pkg::cmd_type              cmd,
   output cht_pkg::sts_type              sts,
   output logic [cht_pkg::ValueWidth-1:0] val_q,
   output logic [cht_pkg::CountW-1:0]    count
);
   logic [cht_pkg::KeyW-1:0] rkey_ff, rkey_in;
   logic [3:0]    rlen_ff, rlen_in;
   logic [cht_pkg::KeyW-1:0] hkey_ff;
   logic [3:0]    hlen_ff;
   logic [cht_pkg::ValueWidth-1:0] hval_ff;
   logic          hvalid_ff;
   logic [cht_pkg::ValueWidth-1:0] vq_ff;
   logic [cht_pkg::CountW-1:0] cnt_ff;
   logic [cht_pkg::SlotW-1:0] slot_ff;
   logic [cht_pkg::SlotW-1:0] clr_ff;
   logic [cht_pkg::KickW-1:0] kick_ff;

   logic [cht_pkg::WordW-1:0] mem [cht_pkg::SlotCount];
   logic [cht_pkg::WordW-1:0] rd_ff;
   logic [cht_pkg::SlotW-1:0] logm [cht_pkg::MaxKicks+1];
   logic [cht_pkg::SlotW-1:0] lg_ff;

   logic [cht_pkg::SizeW-1:0] modv;
   logic hstart;
   logic [cht_pkg::IdxW-1:0] hidx;
   logic hdone;
   logic [3:0] clen;
   logic [cht_pkg::KeyW-1:0] cmask;
   logic [cht_pkg::SlotW-1:0] hslot;
   logic [cht_pkg::KickW-1:0] kdec;

   always_comb begin
      modv = size;
      if (size == '0) modv = 9'd1;
      if (size > 9'(cht_pkg::SubDepth)) modv = 9'(cht_pkg::SubDepth);
      clen = (req.key_length > 4'(cht_pkg::KeyMaxBytes)) ? 4'(cht_pkg::KeyMaxBytes)
                                                         : req.key_length;
      cmask = '1;
      if (clen < 4'd8) cmask = (64'd1 << {clen[2:0], 3'b000}) - 64'd1;
      rkey_in = req.key_bytes & cmask;
      rlen_in = clen;
      hslot = {cmd.way_sel, hidx};
      kdec = kick_ff - cht_pkg::KickW'(1);
   end

   assign hstart = (cmd.op == cht_pkg::OP_HASH);

   cht_hash u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hstart),
      .way     (cmd.way_sel),
      .key     (hkey_ff),
      .len     (hlen_ff),
      .modulus (modv),
      .done    (hdone),
      .index   (hidx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         clr_ff <= '0;
      end else begin
         if (cmd.cnt_inc) cnt_ff <= cnt_ff + cht_pkg::CountW'(1);
         else if (cmd.cnt_dec && cnt_ff != '0) cnt_ff <= cnt_ff - cht_pkg::CountW'(1);
         if (cmd.op == cht_pkg::OP_INIT) clr_ff <= clr_ff + cht_pkg::SlotW'(1);
      end
   end

   always_ff @(posedge clock) begin
      // newest logged slot, registered from kick_ff
      lg_ff <= logm[kdec[cht_pkg::LogW-1:0]];
      case (cmd.op)
         cht_pkg::OP_INIT: mem[clr_ff] <= '0;
         cht_pkg::OP_LOAD: begin
            rkey_ff   <= rkey_in;
            rlen_ff   <= rlen_in;
            hkey_ff   <= rkey_in;
            hlen_ff   <= rlen_in;
            hval_ff   <= req.value_in;
            hvalid_ff <= 1'b1;
            kick_ff   <= '0;
            vq_ff     <= '0;
         end
         cht_pkg::OP_READ: begin
            slot_ff <= hslot;
            rd_ff   <= mem[hslot];
         end
         cht_pkg::OP_UNDO: begin
            slot_ff <= lg_ff;
            rd_ff   <= mem[lg_ff];
            kick_ff <= kdec;
         end
         cht_pkg::OP_SETVAL:
            mem[slot_ff] <= {rd_ff[cht_pkg::WordW-1:cht_pkg::ValueWidth], hval_ff};
         cht_pkg::OP_CLRVAL:
            mem[slot_ff] <= {1'b0, rd_ff[cht_pkg::WordW-2:0]};
         cht_pkg::OP_LOOKVAL: vq_ff <= rd_ff[cht_pkg::ValueWidth-1:0];
         cht_pkg::OP_SWAP, cht_pkg::OP_USWAP: begin
            mem[slot_ff] <= {hvalid_ff, hkey_ff, hlen_ff, hval_ff};
            {hvalid_ff, hkey_ff, hlen_ff, hval_ff} <= rd_ff;
            if (cmd.op == cht_pkg::OP_SWAP) begin
               logm[kick_ff[cht_pkg::LogW-1:0]] <= slot_ff;
               kick_ff <= kick_ff + cht_pkg::KickW'(1);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      sts.hash_done = hdone;
      sts.match     = rd_ff[cht_pkg::WordW-1] &&
                      rd_ff[cht_pkg::WordW-2:cht_pkg::ValueWidth] == {rkey_ff, rlen_ff};
      sts.hand_free = !hvalid_ff;
      sts.hand_own  = hkey_ff == rkey_ff && hlen_ff == rlen_ff;
      // kick_ff counts placements; moves = placements - 1
      sts.kick_max  = kick_ff == cht_pkg::KickW'(cht_pkg::MaxKicks + 1);
      sts.log_empty = kick_ff == '0;
      sts.init_last = clr_ff == '1;
   end

   assign val_q = vq_ff;
   assign count = cnt_ff;
endmodule

// ===== rtl/core/cht_ctrl.sv =====
module cht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        kind,
   input  cht_pkg::sts_type  sts,
   output cht_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              done,
   output logic [1:0]        status
);
   typedef enum logic [13:0] {
      S_INIT  = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_PHASH = 14'b00000000000100,
      S_PWAIT = 14'b00000000001000,
      S_PREAD = 14'b00000000010000,
      S_PCHK  = 14'b00000000100000,
      S_KHASH = 14'b00000001000000,
      S_KWAIT = 14'b00000010000000,
      S_KREAD = 14'b00000100000000,
      S_KSWAP = 14'b00001000000000,
      S_KCHK  = 14'b00010000000000,
      S_UNDO  = 14'b00100000000000,
      S_USWAP = 14'b01000000000000,
      S_FIN   = 14'b10000000000000
   } state_type;

   state_type st_ff, st_in;
   logic [1:0] kind_ff, kind_in;
   logic [1:0] way_ff, way_in;
   logic [1:0] stat_ff, stat_in;

   always_comb begin
      st_in   = st_ff;
      kind_in = kind_ff;
      way_in  = way_ff;
      stat_in = stat_ff;
      cmd     = '{op: cht_pkg::OP_NONE, way_sel: way_ff, cnt_inc: 1'b0, cnt_dec: 1'b0};
      case (st_ff)
         S_INIT: begin
            // clearing pass over every slot after reset
            cmd.op = cht_pkg::OP_INIT;
            if (sts.init_last) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op  = cht_pkg::OP_LOAD;
               kind_in = kind;
               way_in  = 2'd0;
               st_in   = (kind == cht_pkg::KIND_NONE) ? S_FIN : S_PHASH;
               stat_in = cht_pkg::ST_ABSENT;
            end
         end
         S_PHASH: begin
            cmd.op = cht_pkg::OP_HASH;
            st_in  = S_PWAIT;
         end
         S_PWAIT: if (sts.hash_done) st_in = S_PREAD;
         S_PREAD: begin
            cmd.op = cht_pkg::OP_READ;
            st_in  = S_PCHK;
         end
         S_PCHK: begin
            if (sts.match) begin
               st_in = S_FIN;
               case (kind_ff)
                  cht_pkg::KIND_INSERT: begin
                     cmd.op  = cht_pkg::OP_SETVAL;
                     stat_in = cht_pkg::ST_REPLACED;
                  end
                  cht_pkg::KIND_LOOKUP: begin
                     cmd.op  = cht_pkg::OP_LOOKVAL;
                     stat_in = cht_pkg::ST_OK;
                  end
                  default: begin
                     cmd.op      = cht_pkg::OP_CLRVAL;
                     cmd.cnt_dec = 1'b1;
                     stat_in     = cht_pkg::ST_OK;
                  end
               endcase
            end else if (way_ff != 2'd3) begin
               way_in = way_ff + 2'd1;
               st_in  = S_PHASH;
            end else if (kind_ff == cht_pkg::KIND_INSERT) begin
               way_in = 2'd0;
               st_in  = S_KHASH;
            end else st_in = S_FIN;
         end
         S_KHASH: begin
            cmd.op = cht_pkg::OP_HASH;
            st_in  = S_KWAIT;
         end
         S_KWAIT: if (sts.hash_done) st_in = S_KREAD;
         S_KREAD: begin
            cmd.op = cht_pkg::OP_READ;
            st_in  = S_KSWAP;
         end
         S_KSWAP: begin
            cmd.op = cht_pkg::OP_SWAP;
            st_in  = S_KCHK;
         end
         S_KCHK: begin
            // hand now holds the cell taken out
            if (sts.hand_free) begin
               cmd.cnt_inc = 1'b1;
               stat_in     = cht_pkg::ST_OK;
               st_in       = S_FIN;
            end else if (sts.hand_own) begin
               stat_in = cht_pkg::ST_FULL;
               st_in   = S_FIN;
            end else if (sts.kick_max) begin
               stat_in = cht_pkg::ST_FULL;
               st_in   = S_UNDO;
            end else begin
               way_in = way_ff + 2'd1;
               st_in  = S_KHASH;
            end
         end
         S_UNDO: begin
            cmd.op = cht_pkg::OP_UNDO;
            st_in  = S_USWAP;
         end
         S_USWAP: begin
            cmd.op = cht_pkg::OP_USWAP;
            st_in  = sts.log_empty ? S_FIN : S_UNDO;
         end
         S_FIN: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_INIT;
      else st_ff <= st_in;
      kind_ff <= kind_in;
      way_ff  <= way_in;
      stat_ff <= stat_in;
   end

   assign busy   = (st_ff != S_IDLE);
   assign done   = (st_ff == S_FIN);
   assign status = stat_ff;
endmodule

// ===== rtl/core/four_way_cuckoo_hash_table_top.sv =====
// Four-way cuckoo key-value table. An item is taken when start is high and busy
// is low; its one result follows with rsp_valid high for a single cycle and
// cannot be stalled. After reset the block stays busy while a clearing pass
// empties every slot. Each probe hashes the key one byte per cycle and reduces
// it with a bit-serial remainder. An insert of a new key makes at most 33
// cuckoo placements and undoes them when the kick bound is hit. The user must
// write the sub-table size register through csr_ only while the block is idle;
// the block itself does not enforce this.
module four_way_cuckoo_hash_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  cht_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output cht_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cht_pkg::SizeW-1:0]     csr_data
);
   logic [cht_pkg::SizeW-1:0] size_ff;
   cht_pkg::cmd_type cmd;
   cht_pkg::sts_type sts;
   logic [cht_pkg::ValueWidth-1:0] vq;
   logic [cht_pkg::CountW-1:0] cnt;
   logic done;
   logic [1:0] stat;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= 9'(cht_pkg::SubDepth);
      else if (csr_valid && csr_ready) size_ff <= csr_data;
   end
   assign csr_ready = 1'b1;

   cht_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .kind (req_data.kind),
      .sts (sts), .cmd (cmd), .busy (busy), .done (done), .status (stat)
   );

   cht_datapath u_dp (
      .clock (clock), .reset (reset), .req (req_data), .size (size_ff),
      .cmd (cmd), .sts (sts), .val_q (vq), .count (cnt)
   );

   assign rsp_valid           = done;
   assign rsp_data.status     = stat;
   assign rsp_data.value_out  = (stat == cht_pkg::ST_OK) ? vq : '0;
   assign rsp_data.occupancy  = cnt;
endmodule

// ===== rtl/core/cht_checker.sv =====
`include "four_way_cuckoo_hash_table_top_defines.svh"
module cht_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input cht_pkg::rsp_type rsp_data
);
   `CHT_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy)
   `CHT_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   `CHT_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy)
   `CHT_ASSERT_IMP(a_occ_range, clock, reset, rsp_valid, rsp_data.occupancy <= 11'd1024)
endmodule

bind four_way_cuckoo_hash_table_top cht_checker u_cht_checker (
   .clock (clock), .reset (reset), .start (start), .busy (busy),
   .rsp_valid (rsp_valid), .rsp_data (rsp_data)
);
